/* design/tcgbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcgbs_pkg;

  // Table shape
  localparam int COLUMNS    = 8;
  localparam int BUCKETS    = 8;
  localparam int SUM_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int MODE_BITS  = 2;

  // Derived store geometry
  localparam int COMBOS     = COLUMNS * (COLUMNS - 1) * (COLUMNS - 2) / 6;
  localparam int CUBE       = BUCKETS * BUCKETS * BUCKETS;
  localparam int DEPTH      = COMBOS * CUBE;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int BKT_BITS   = $clog2(BUCKETS);
  localparam int COL_BITS   = $clog2(COLUMNS);
  localparam int COMBO_BITS = $clog2(COMBOS);

  typedef logic [BKT_BITS-1:0] bkt_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ACC      = 2'd0,
    MODE_READ     = 2'd1,
    MODE_READ_CLR = 2'd2,
    MODE_NOP      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_ACC_DRAIN,
    ST_RD_ISSUE,
    ST_RD_DATA
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic acc_step;  // read bin of current triple, advance triple
    logic rd_issue;  // read addressed bin
    logic rd_finish; // load result register, clear bin if asked
    logic clr_step;  // zero one bin of the clearing pass
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass at last bin
    logic acc_last;  // current triple is the last one
    logic out_busy;  // result register full and stalled
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/tcgbs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcgbs_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [tcgbs_pkg::MODE_BITS-1:0] in_mode,
  output logic                            in_stall,
  output tcgbs_pkg::ctl_cmd_t             cmd,
  input  wire tcgbs_pkg::dp_sts_t         sts
);
  import tcgbs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (mode_t'(in_mode)) inside
            MODE_ACC:                 state_nxt = ST_ACC;
            MODE_READ, MODE_READ_CLR: state_nxt = ST_RD_ISSUE;
            default:                  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_last) begin
          state_nxt = ST_ACC_DRAIN;
        end
      end
      ST_ACC_DRAIN: begin
        // last pending write lands this cycle
        state_nxt = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        // hold read data until the result register frees up
        if (!sts.out_busy) begin
          cmd.rd_finish = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/tcgbs_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcgbs_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire tcgbs_pkg::ctl_cmd_t                  cmd,
  output tcgbs_pkg::dp_sts_t                        sts,
  input  wire logic [tcgbs_pkg::MODE_BITS-1:0]      in_mode,
  input  wire tcgbs_pkg::bkt_t [tcgbs_pkg::COLUMNS-1:0] in_bkt,
  input  wire logic signed [tcgbs_pkg::VALUE_BITS-1:0] in_row_value,
  input  wire logic [tcgbs_pkg::ADDR_BITS-1:0]      in_bin_address,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [tcgbs_pkg::SUM_BITS-1:0]     out_bin_sum
);
  import tcgbs_pkg::*;

  localparam logic [COL_BITS-1:0]   COL_LAST   = COL_BITS'(COLUMNS - 1);
  localparam logic [COMBO_BITS-1:0] COMBO_LAST = COMBO_BITS'(COMBOS - 1);
  localparam logic [ADDR_BITS-1:0]  ADDR_LAST  = ADDR_BITS'(DEPTH - 1);

  // Bin store
  logic [SUM_BITS-1:0] mem [DEPTH];
  logic [SUM_BITS-1:0] rdata_r;
  logic                mem_re;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic                mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [SUM_BITS-1:0] mem_wdata;

  // Captured beat
  mode_t                     mode_r;
  bkt_t [COLUMNS-1:0]        bkt_r;
  logic signed [SUM_BITS-1:0] value_r;
  logic [ADDR_BITS-1:0]      rd_addr_r;
  logic                      rd_in_range;

  // Triple walk
  logic [COL_BITS-1:0]   i_r, j_r, k_r;
  logic [COL_BITS-1:0]   i_nxt, j_nxt, k_nxt;
  logic [COMBO_BITS-1:0] combo_r;
  logic [ADDR_BITS-1:0]  acc_addr;

  // Pending accumulate write, clearing pass, result register
  logic                 wr_pend_r;
  logic [ADDR_BITS-1:0] wr_addr_r;
  logic [ADDR_BITS-1:0] clr_addr_r;
  logic                 out_valid_r;
  logic [SUM_BITS-1:0]  out_sum_r;

  // Capture beat fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode_t'(in_mode);
      bkt_r     <= in_bkt;
      value_r   <= SUM_BITS'(in_row_value);
      rd_addr_r <= in_bin_address;
    end
  end

  assign rd_in_range = (rd_addr_r <= ADDR_LAST);

  // Bin address of the current triple
  assign acc_addr = ADDR_BITS'(combo_r) * ADDR_BITS'(CUBE)
                  + ADDR_BITS'(bkt_r[i_r]) * ADDR_BITS'(BUCKETS * BUCKETS)
                  + ADDR_BITS'(bkt_r[j_r]) * ADDR_BITS'(BUCKETS)
                  + ADDR_BITS'(bkt_r[k_r]);

  // Next triple in lexicographic order
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (k_r != COL_LAST) begin
      k_nxt = k_r + COL_BITS'(1);
    end else if (j_r != COL_LAST - COL_BITS'(1)) begin
      j_nxt = j_r + COL_BITS'(1);
      k_nxt = j_r + COL_BITS'(2);
    end else begin
      i_nxt = i_r + COL_BITS'(1);
      j_nxt = i_r + COL_BITS'(2);
      k_nxt = i_r + COL_BITS'(3);
    end
  end

  // Advance triple counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_r     <= COL_BITS'(0);
      j_r     <= COL_BITS'(1);
      k_r     <= COL_BITS'(2);
      combo_r <= '0;
    end else if (cmd.acc_step) begin
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      combo_r <= combo_r + COMBO_BITS'(1);
    end
  end

  // Control registers: pending write, clearing pass, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r   <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.acc_step;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_BITS'(1);
      end
      if (cmd.rd_finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Remember where the read-modify-write lands
  always_ff @(posedge clk) begin
    if (cmd.acc_step) begin
      wr_addr_r <= acc_addr;
    end
  end

  // Load result beat
  always_ff @(posedge clk) begin
    if (cmd.rd_finish) begin
      out_sum_r <= rd_in_range ? rdata_r : '0;
    end
  end

  // Memory port select
  always_comb begin
    mem_re    = cmd.acc_step || (cmd.rd_issue && rd_in_range);
    mem_raddr = cmd.acc_step ? acc_addr : rd_addr_r;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = rdata_r + value_r;
    end else if (cmd.rd_finish && rd_in_range && (mode_r == MODE_READ_CLR)) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_r;
    end
  end

  // Bin store write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Bin store read, data held until the next read
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign sts.clr_last = (clr_addr_r == ADDR_LAST);
  assign sts.acc_last = (combo_r == COMBO_LAST);
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid   = out_valid_r;
  assign out_bin_sum = out_sum_r;

endmodule

`default_nettype wire

/* design/triple_column_group_by_sum_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Three-column group-by sum store.
// Input channel (in_valid / in_stall): one beat is a row or a bin request.
//   Mode accumulate adds in_row_value to one bin per column triple (56 bins
//   at 8 columns); mode read returns a bin; mode read-and-clear returns it
//   and zeroes it. Mode 3 is taken and ignored.
// Result channel (out_valid / out_stall): one beat per read request, carrying
//   the bin's sum before any clear. Reads outside the store return zero.
// An accumulate row keeps the input stalled while it walks its triples
//   (one read-modify-write per triple, pipelined through the store's read
//   and write ports, then a drain state); only then is the next row taken.
// A read beat passes an issue state, which reads the bin, and a data state,
//   which loads the result register; the block then takes the next beat.
// A finished result waits in the output register while the block takes the
//   next beat; a further read waits only while that register stays stalled.
// Reset: a clearing pass zeroes all 28672 bins, one per cycle, with in_stall
//   high; the block takes its first beat once the pass is through.
module triple_column_group_by_sum_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [tcgbs_pkg::MODE_BITS-1:0]       in_mode,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_0,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_1,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_2,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_3,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_4,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_5,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_6,
  input  wire logic [tcgbs_pkg::BKT_BITS-1:0]        in_bucket_7,
  input  wire logic signed [tcgbs_pkg::VALUE_BITS-1:0] in_row_value,
  input  wire logic [tcgbs_pkg::ADDR_BITS-1:0]       in_bin_address,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [tcgbs_pkg::SUM_BITS-1:0]      out_bin_sum
);
  import tcgbs_pkg::*;

  ctl_cmd_t           cmd;
  dp_sts_t            sts;
  bkt_t [COLUMNS-1:0] bkt;

  // Gather bucket codes by column
  assign bkt[0] = in_bucket_0;
  assign bkt[1] = in_bucket_1;
  assign bkt[2] = in_bucket_2;
  assign bkt[3] = in_bucket_3;
  assign bkt[4] = in_bucket_4;
  assign bkt[5] = in_bucket_5;
  assign bkt[6] = in_bucket_6;
  assign bkt[7] = in_bucket_7;

  tcgbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  tcgbs_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_bkt         (bkt),
    .in_row_value   (in_row_value),
    .in_bin_address (in_bin_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_sum    (out_bin_sum)
  );

`ifndef SYNTHESIS
  // The drain state separates the last update of a row from any later read
  a_acc_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_step && sts.acc_last) |=> !cmd.acc_step)
    else $error("accumulate read issued without drain cycle");

  // Never overwrite a stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_finish |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // No beat is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> in_stall)
    else $error("input accepted during clearing pass");

  // A result is loaded only after the read of its bin has been issued
  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_finish |-> $past(cmd.rd_issue) || $past(sts.out_busy))
    else $error("result loaded without a preceding bin read");
`endif

endmodule

`default_nettype wire

/* tb/tcgbs_bin_sum_monitor.sv */
`timescale 1ns / 1ps

// Watches both channels, mirrors the bin store and checks every result beat.
module tcgbs_bin_sum_monitor
  import tcgbs_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [MODE_BITS-1:0]         in_mode,
  input  wire logic [COLUMNS*BKT_BITS-1:0]  in_codes,
  input  wire logic signed [VALUE_BITS-1:0] in_row_value,
  input  wire logic [ADDR_BITS-1:0]         in_bin_address,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic signed [SUM_BITS-1:0]   out_bin_sum,
  output int                                mismatch_count,
  output int                                sums_outstanding
);

  logic [SUM_BITS-1:0] mirror_bins [DEPTH];
  logic [SUM_BITS-1:0] sums_due [$];
  logic [SUM_BITS-1:0] want;
  int                  errors;

  assign mismatch_count = errors;

  // Apply one accepted beat to the mirrored store; queue the sum a read returns
  function automatic void apply_beat(input mode_t mode,
                                     input logic [COLUMNS*BKT_BITS-1:0] codes,
                                     input logic [VALUE_BITS-1:0] value,
                                     input logic [ADDR_BITS-1:0] addr);
    int combo;
    int slot;
    logic [SUM_BITS-1:0] sum;
    combo = 0;
    sum = '0;
    case (mode)
      MODE_ACC: begin
        // walk the column triples in lexicographic order
        for (int i = 0; i < COLUMNS - 2; i++) begin
          for (int j = i + 1; j < COLUMNS - 1; j++) begin
            for (int k = j + 1; k < COLUMNS; k++) begin
              slot = combo * CUBE
                   + int'(codes[i*BKT_BITS +: BKT_BITS]) * BUCKETS * BUCKETS
                   + int'(codes[j*BKT_BITS +: BKT_BITS]) * BUCKETS
                   + int'(codes[k*BKT_BITS +: BKT_BITS]);
              mirror_bins[slot] = mirror_bins[slot] + SUM_BITS'(value);
              combo++;
            end
          end
        end
      end
      MODE_READ, MODE_READ_CLR: begin
        // out-of-range reads return zero and clear nothing
        if (int'(addr) < DEPTH) begin
          sum = mirror_bins[addr];
          if (mode == MODE_READ_CLR)
            mirror_bins[addr] = '0;
        end
        sums_due = {sums_due, sum};
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < DEPTH; a++)
        mirror_bins[a] = '0;
      sums_due.delete();
      errors = 0;
    end else begin
      // check the result beat against the oldest pending read
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          $error("bin_sum: expected no beat, actual %0d", out_bin_sum);
          errors++;
        end else begin
          want = sums_due.pop_front();
          if (out_bin_sum !== want) begin
            $error("bin_sum: expected %0d, actual %0d", $signed(want), out_bin_sum);
            errors++;
          end
        end
      end
      // advance the mirror on an input beat
      if (in_valid && !in_stall)
        apply_beat(mode_t'(in_mode), in_codes, in_row_value, in_bin_address);
    end
    sums_outstanding <= sums_due.size();
  end

endmodule

/* tb/tb_triple_column_group_by_sum_core.sv */
`timescale 1ns / 1ps

module tb_triple_column_group_by_sum_core
  import tcgbs_pkg::*;
;

  localparam int RANDOM_ROWS = 1130;
  localparam int CALM_ROWS   = 130;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [MODE_BITS-1:0]         in_mode;
  logic [COLUMNS*BKT_BITS-1:0]  in_codes;
  logic signed [VALUE_BITS-1:0] in_row_value;
  logic [ADDR_BITS-1:0]         in_bin_address;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SUM_BITS-1:0]   out_bin_sum;
  int                           mismatch_count;
  int                           sums_outstanding;
  int                           idle_pct;
  int                           stall_pct;
  bit                           calm;

  triple_column_group_by_sum_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_bucket_0    (in_codes[0*BKT_BITS +: BKT_BITS]),
    .in_bucket_1    (in_codes[1*BKT_BITS +: BKT_BITS]),
    .in_bucket_2    (in_codes[2*BKT_BITS +: BKT_BITS]),
    .in_bucket_3    (in_codes[3*BKT_BITS +: BKT_BITS]),
    .in_bucket_4    (in_codes[4*BKT_BITS +: BKT_BITS]),
    .in_bucket_5    (in_codes[5*BKT_BITS +: BKT_BITS]),
    .in_bucket_6    (in_codes[6*BKT_BITS +: BKT_BITS]),
    .in_bucket_7    (in_codes[7*BKT_BITS +: BKT_BITS]),
    .in_row_value   (in_row_value),
    .in_bin_address (in_bin_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_sum    (out_bin_sum)
  );

  tcgbs_bin_sum_monitor bin_sum_mon (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_codes         (in_codes),
    .in_row_value     (in_row_value),
    .in_bin_address   (in_bin_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bin_sum      (out_bin_sum),
    .mismatch_count   (mismatch_count),
    .sums_outstanding (sums_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bin hit by the given triple number of a row with these codes
  function automatic logic [ADDR_BITS-1:0] bin_of(input logic [COLUMNS*BKT_BITS-1:0] codes,
                                                  input int pick);
    int combo;
    int hit;
    combo = 0;
    hit = 0;
    for (int i = 0; i < COLUMNS - 2; i++) begin
      for (int j = i + 1; j < COLUMNS - 1; j++) begin
        for (int k = j + 1; k < COLUMNS; k++) begin
          if (combo == pick)
            hit = combo * CUBE
                + int'(codes[i*BKT_BITS +: BKT_BITS]) * BUCKETS * BUCKETS
                + int'(codes[j*BKT_BITS +: BKT_BITS]) * BUCKETS
                + int'(codes[k*BKT_BITS +: BKT_BITS]);
          combo++;
        end
      end
    end
    return ADDR_BITS'(hit);
  endfunction

  // Present one beat and hold it until taken
  task automatic send_beat(input mode_t mode, input logic [COLUMNS*BKT_BITS-1:0] codes,
                           input logic [VALUE_BITS-1:0] value,
                           input logic [ADDR_BITS-1:0] addr);
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_codes       <= codes;
    in_row_value   <= value;
    in_bin_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid for a random burst
  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off until every pending read has returned
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_outstanding != 0) @(posedge clk);
  endtask

  // Result side stalls in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_400_000;
    $display("tb_triple_column_group_by_sum_core: FAIL");
    $finish;
  end

  initial begin
    logic [COLUMNS*BKT_BITS-1:0] pool [6];
    logic [COLUMNS*BKT_BITS-1:0] codes;
    logic [VALUE_BITS-1:0]       value;
    logic [ADDR_BITS-1:0]        addr;
    mode_t                       mode;
    int                          r;
    int                          pct_by_phase [6];

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_ACC;
    in_codes       = '0;
    in_row_value   = '0;
    in_bin_address = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    calm           = 1'b0;
    pct_by_phase   = '{0, 15, 40, 70, 25, 5};
    for (int p = 0; p < 6; p++)
      pool[p] = (COLUMNS*BKT_BITS)'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fresh store, wrap, extreme codes, address bounds, ignored mode
    send_beat(MODE_READ, '0, '0, '0);
    send_beat(MODE_ACC, '0, 32'h7FFF_FFFF, '0);
    send_beat(MODE_ACC, '0, 32'h7FFF_FFFF, '0);
    send_beat(MODE_READ, '0, '0, bin_of('0, 0));
    send_beat(MODE_ACC, '1, 32'h8000_0000, '0);
    send_beat(MODE_READ_CLR, '0, '0, bin_of('1, 0));
    send_beat(MODE_READ, '0, '0, bin_of('1, 0));
    send_beat(MODE_NOP, '0, 32'h1234_5678, ADDR_BITS'(DEPTH - 1));
    send_beat(MODE_READ_CLR, '0, '0, ADDR_BITS'(DEPTH - 1));
    send_beat(MODE_READ_CLR, '0, '0, ADDR_BITS'(DEPTH));
    send_beat(MODE_READ, '0, '0, '1);
    send_beat(MODE_ACC, 24'o76543210, 32'd1, '0);
    send_beat(MODE_ACC, 24'o76543210, 32'hFFFF_FFFF, '0);
    send_beat(MODE_ACC, 24'o76543210, 32'd5, '0);
    send_beat(MODE_READ, '0, '0, bin_of(24'o76543210, 0));
    send_beat(MODE_READ_CLR, '0, '0, bin_of(24'o76543210, COMBOS - 1));
    send_beat(MODE_READ, '0, '0, bin_of(24'o76543210, COMBOS - 1));
    send_beat(MODE_ACC, 24'o01234567, 32'd12345, '0);
    send_beat(MODE_READ, '0, '0, bin_of(24'o01234567, 27));
    wait_drained();

    // Random: rows lean on a few patterns so reads land on populated bins
    for (int n = 0; n < RANDOM_ROWS; n++) begin
      if (n % 200 == 0) begin
        wait_drained();
        idle_pct  = pct_by_phase[(n / 200) % 6];
        stall_pct = pct_by_phase[(n / 200 + 2) % 6];
      end
      if (n == RANDOM_ROWS - CALM_ROWS)
        calm = 1'b1;

      r = $urandom_range(0, 9);
      if (r < 5)
        codes = pool[$urandom_range(0, 5)];
      else if (r < 8)
        codes = (COLUMNS*BKT_BITS)'($urandom);
      else
        codes = (COLUMNS*BKT_BITS)'($urandom) & 24'o11111111;

      r = $urandom_range(0, 9);
      if (r < 5)
        value = VALUE_BITS'($urandom_range(0, 200)) - 32'd100;
      else if (r < 8)
        value = $urandom;
      else if (r == 8)
        value = 32'h7FFF_FFFF;
      else
        value = 32'h8000_0000;

      r = $urandom_range(0, 9);
      if (r < 6)
        addr = bin_of(pool[$urandom_range(0, 5)], $urandom_range(0, COMBOS - 1));
      else if (r < 8)
        addr = ADDR_BITS'($urandom_range(0, DEPTH - 1));
      else
        addr = ADDR_BITS'($urandom);

      r = $urandom_range(0, 19);
      if (r < 11)
        mode = MODE_ACC;
      else if (r < 15)
        mode = MODE_READ;
      else if (r < 19)
        mode = MODE_READ_CLR;
      else
        mode = MODE_NOP;

      send_beat(mode, codes, value, addr);
      maybe_idle();
    end

    // Drain, then allow a row's worth of cycles for stray beats
    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_triple_column_group_by_sum_core: PASS");
    else
      $display("tb_triple_column_group_by_sum_core: FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/tcgbs_pkg.sv
design/tcgbs_ctrl.sv
design/tcgbs_dpath.sv
design/triple_column_group_by_sum_core.sv
tb/tcgbs_bin_sum_monitor.sv
tb/tb_triple_column_group_by_sum_core.sv
